// ===== design/u8f_pkg.sv =====
// Package for the UTF-8 validating filter: the queue entry type and the
// code-point limits used by the classifier. No dependencies.
package u8f_pkg;

  localparam int unsigned U8F_QDEPTH = 4;

  localparam logic [1:0]  KIND_CONT     = 2'b10;
  localparam logic [1:0]  KIND_LEAD     = 2'b11;
  localparam logic [10:0] OVERLONG2_MAX = 11'h07F;
  localparam logic [15:0] OVERLONG3_MAX = 16'h07FF;
  localparam logic [15:0] SURROGATE_MIN = 16'hD800;
  localparam logic [15:0] ERR_MAX       = 16'hFFFF;

  // One queue entry: a whole emitted group of one to three bytes.
  typedef struct packed {
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [1:0]  last_idx;
    logic        replaced;
    logic [15:0] err;
  } u8f_grp_t;

endpackage

// ===== design/u8f_front.sv =====
// Front end of the UTF-8 filter: accepts raw bytes, tracks the pending
// sequence and builds one group entry per completed or rejected sequence.
// Depends on u8f_pkg.
module u8f_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_replacement_byte,
  input  logic             acc,
  input  logic [7:0]       in_byte,
  output logic             push,
  output u8f_pkg::u8f_grp_t grp
);
  import u8f_pkg::*;

  logic [7:0]  repl_r;
  logic [1:0]  be_r, be_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [15:0] err_r, err_nxt;
  logic [15:0] err_inc;
  logic [1:0]  kind;
  logic [1:0]  be_dec;
  logic [10:0] v2;
  logic [15:0] v3;
  logic        emit;
  logic        do_rep;

  assign kind    = in_byte[7:6];
  assign be_dec  = be_r - 2'd1;
  assign err_inc = (err_r == ERR_MAX) ? err_r : err_r + 16'd1;
  assign v2      = {held0_r[4:0], in_byte[5:0]};
  assign v3      = {held0_r[3:0], held1_r[5:0], in_byte[5:0]};

  always_comb begin
    be_nxt    = be_r;
    hc_nxt    = hc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    emit      = 1'b0;
    do_rep    = 1'b0;
    grp       = '0;
    grp.err   = err_r;
    if (kind == KIND_LEAD) begin
      if (be_r != 2'd0 || (in_byte[5] && in_byte[4])) begin
        do_rep = 1'b1;
      end else begin
        be_nxt    = in_byte[5] ? 2'd2 : 2'd1;
        held0_nxt = in_byte;
        hc_nxt    = 2'd1;
      end
    end else if (kind == KIND_CONT) begin
      if (be_r == 2'd0) begin
        do_rep = 1'b1;
      end else if (be_dec != 2'd0) begin
        be_nxt = be_dec;
        if (hc_r >= 2'd2) begin
          do_rep = 1'b1;
        end else begin
          if (hc_r[0]) held1_nxt = in_byte;
          else         held0_nxt = in_byte;
          hc_nxt = hc_r + 2'd1;
        end
      end else if (hc_r == 2'd1) begin
        be_nxt = 2'd0;
        if (v2 <= OVERLONG2_MAX) begin
          do_rep = 1'b1;
        end else begin
          hc_nxt       = 2'd0;
          emit         = 1'b1;
          grp.b0       = held0_r;
          grp.b1       = in_byte;
          grp.last_idx = 2'd1;
        end
      end else if (hc_r == 2'd2) begin
        be_nxt = 2'd0;
        if (v3 <= OVERLONG3_MAX || v3 >= SURROGATE_MIN) begin
          do_rep = 1'b1;
        end else begin
          hc_nxt       = 2'd0;
          emit         = 1'b1;
          grp.b0       = held0_r;
          grp.b1       = held1_r;
          grp.b2       = in_byte;
          grp.last_idx = 2'd2;
        end
      end else begin
        do_rep = 1'b1;
      end
    end else begin
      if (be_r != 2'd0) begin
        do_rep = 1'b1;
      end else begin
        hc_nxt = 2'd0;
        emit   = 1'b1;
        grp.b0 = in_byte;
      end
    end
    if (do_rep) begin
      be_nxt       = 2'd0;
      hc_nxt       = 2'd0;
      emit         = 1'b1;
      grp.b0       = repl_r;
      grp.b1       = '0;
      grp.b2       = '0;
      grp.last_idx = 2'd0;
      grp.replaced = 1'b1;
      grp.err      = err_inc;
    end
    err_nxt = do_rep ? err_inc : err_r;
  end

  assign push = acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= 8'd63;
      be_r   <= '0;
      hc_r   <= '0;
      err_r  <= '0;
    end else begin
      if (cfg_we) repl_r <= cfg_replacement_byte;
      if (acc) begin
        be_r  <= be_nxt;
        hc_r  <= hc_nxt;
        err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

// ===== design/u8f_fifo.sv =====
// Short queue of group entries between the front end and the serializer.
// Depends on u8f_pkg.
module u8f_fifo #(
  parameter int unsigned Depth = u8f_pkg::U8F_QDEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8f_pkg::u8f_grp_t wdata,
  input  logic              pop,
  output u8f_pkg::u8f_grp_t rdata,
  output logic              empty,
  output logic              full
);
  import u8f_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  u8f_grp_t        mem [Depth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CntFull);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PtrLast) ? '0 : wp_r + PtrW'(1);
      if (do_pop)  rp_r <= (rp_r == PtrLast) ? '0 : rp_r + PtrW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CntW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wdata;
  end

endmodule

// ===== design/u8f_back.sv =====
// Serializer: walks the head queue entry byte by byte onto the result channel.
// Depends on u8f_pkg.
module u8f_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u8f_pkg::u8f_grp_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_replaced,
  output logic [15:0]       out_error_count
);
  import u8f_pkg::*;

  logic [1:0] idx_r;
  logic       beat;

  assign out_valid       = !empty;
  assign beat            = out_valid && !out_stall;
  assign out_last        = (idx_r == head.last_idx);
  assign out_replaced    = head.replaced;
  assign out_error_count = head.err;
  assign pop             = beat && out_last;

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = head.b0;
      2'd1:    out_byte = head.b1;
      default: out_byte = head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (beat) begin
      idx_r <= out_last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// ===== design/utf8_bmp_validating_filter.sv =====
// Top level of the UTF-8 validating filter (one to three byte sequences).
// Ties the front end, the group queue and the serializer; uses u8f_pkg.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    in_byte
//   out       output     out_valid / out_stall  out_byte, out_last, out_replaced,
//                                               out_error_count
//   cfg       input      cfg_we                 cfg_replacement_byte
//
// The front end takes one byte per cycle while the queue is not full and classifies
// it in the same cycle; a completed or rejected sequence becomes one queue entry at that edge.
// The serializer drives one result beat per cycle while out_stall is low, straight from the queue
// head, so a byte can emerge the cycle after it was accepted.
// A three byte sequence holds its entry for one output beat per byte, matching its
// input bytes taken one per cycle, so the average is one beat per cycle while
// out_stall is low; in_stall rises only when the queue is full.
// Reset is synchronous and active low: it empties the queue, clears the
// pending sequence and the error count and sets the replacement byte to 63.
module utf8_bmp_validating_filter #(
  parameter int unsigned QueueDepth = u8f_pkg::U8F_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_replacement_byte,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_replaced,
  output logic [15:0] out_error_count
);
  import u8f_pkg::*;

  u8f_grp_t grp;
  u8f_grp_t head;
  logic     push, pop, empty, full, acc;

  // Stalling on a full queue is conservative: bytes that emit nothing
  // wait too, which keeps in_stall a decode of the queue count alone.
  assign in_stall = full;
  assign acc      = in_valid && !full;

  u8f_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_replacement_byte (cfg_replacement_byte),
    .acc                  (acc),
    .in_byte              (in_byte),
    .push                 (push),
    .grp                  (grp)
  );

  u8f_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (grp),
    .pop   (pop),
    .rdata (head),
    .empty (empty),
    .full  (full)
  );

  u8f_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_replaced    (out_replaced),
    .out_error_count (out_error_count)
  );

endmodule

// ===== design/u8f_checker.sv =====
// Port-level checks for the UTF-8 validating filter, bound to the top level.
// Depends only on the top level's ports.
module u8f_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        out_replaced,
  input logic [15:0] out_error_count
);

  // A replacement is always a one-beat group.
  a_rep_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |-> out_last)
    else $error("replacement beat without last");

  // The rest of a sequence is ready right after each of its accepted non-last beats.
  a_seq_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside an emitted sequence");

  // All beats of one sequence report the same error count.
  a_seq_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_error_count == $past(out_error_count))
    else $error("error count changed inside a sequence");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result beat changed");

endmodule

bind utf8_bmp_validating_filter u8f_checker u_u8f_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last        (out_last),
  .out_replaced    (out_replaced),
  .out_error_count (out_error_count)
);
